// File: hdl/shld_pkg.sv
// Package for the sync header length deframer.
// Holds the field widths, sync and control byte codes, result kinds and reset values.
// No dependencies.
`timescale 1ns / 1ps

package shld_pkg;

  localparam int unsigned ByteBits      = 8;
  localparam int unsigned KindBits      = 2;
  localparam int unsigned MagicBits     = 64;
  localparam int unsigned LineCfgBits   = 14;
  localparam int unsigned LineCntBits   = 13;
  localparam int unsigned CfgIndexBits  = 1;
  localparam int unsigned CfgDataBits   = 64;
  localparam int unsigned HeaderBytes   = 32;
  localparam int unsigned HeaderBits    = HeaderBytes * ByteBits;
  localparam int unsigned HdrCntBits    = $clog2(HeaderBytes);
  localparam int unsigned WordBits      = 64;
  localparam int unsigned LengthBitsDef = 64;

  // Configuration register indexes.
  localparam logic [CfgIndexBits-1:0] CfgMagic   = 1'd0;
  localparam logic [CfgIndexBits-1:0] CfgLineMax = 1'd1;

  localparam logic [MagicBits-1:0]   MagicReset = 64'd314159265;
  localparam logic [LineCfgBits-1:0] LineReset  = 14'd4096;
  localparam logic [LineCfgBits-1:0] LineCap    = 14'd8192;

  // Sync sequence and the newline byte.
  localparam logic [ByteBits-1:0] SyncByte0   = 8'h07;
  localparam logic [ByteBits-1:0] SyncByte1   = 8'h08;
  localparam logic [ByteBits-1:0] SyncByte2   = 8'h0D;
  localparam logic [ByteBits-1:0] SyncByte3   = 8'h09;
  localparam logic [ByteBits-1:0] NewlineByte = 8'h0A;

  // Result kinds.
  localparam logic [KindBits-1:0] KindLog   = 2'd0;
  localparam logic [KindBits-1:0] KindInfo  = 2'd1;
  localparam logic [KindBits-1:0] KindBody  = 2'd2;
  localparam logic [KindBits-1:0] KindEmpty = 2'd3;

endpackage

// File: hdl/sync_header_length_deframer_top.sv
// A result appears in the output register in the cycle after its input beat is accepted.
// Throughput: one byte per cycle; the input stalls only while a held result is stalled.
// The per-byte work is a single pass between the accepted byte and the output register.
// Reset (asynchronous, active low) returns the parser to idle, clears the line count,
// empties the output register and loads the magic and line-limit registers with defaults.
// Depends on shld_pkg for widths, byte codes and result kinds.
`timescale 1ns / 1ps

module sync_header_length_deframer_top #(
  parameter int unsigned LENGTH_BITS = shld_pkg::LengthBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [shld_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [shld_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [shld_pkg::ByteBits-1:0]       in_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [shld_pkg::ByteBits-1:0]       out_byte_o,
  output logic [shld_pkg::KindBits-1:0]       byte_kind_o,
  output logic                                line_end_o,
  output logic                                packet_last_o,
  output logic                                split_error_o
);

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhSync1  = 3'd1;
  localparam logic [2:0] PhSync2  = 3'd2;
  localparam logic [2:0] PhSync3  = 3'd3;
  localparam logic [2:0] PhHeader = 3'd4;
  localparam logic [2:0] PhData   = 3'd5;

  localparam int unsigned HB = shld_pkg::HeaderBits;
  localparam int unsigned WB = shld_pkg::WordBits;
  localparam int unsigned BB = shld_pkg::ByteBits;
  localparam logic [shld_pkg::HdrCntBits-1:0] HdrLast =
    shld_pkg::HdrCntBits'(shld_pkg::HeaderBytes - 1);
  localparam logic [shld_pkg::HdrCntBits-1:0] HdrHalf =
    shld_pkg::HdrCntBits'(shld_pkg::HeaderBytes / 2);

  // Control state.
  logic [2:0]                          phase_q, phase_d;
  logic [shld_pkg::HdrCntBits-1:0]     hdr_cnt_q, hdr_cnt_d;
  logic [shld_pkg::LineCntBits-1:0]    line_len_q, line_len_d;
  logic [shld_pkg::MagicBits-1:0]      magic_q;
  logic [shld_pkg::LineCfgBits-1:0]    line_max_q;
  logic                                out_valid_q;

  // Datapath state.
  logic [HB-1:0]                       hdr_q, hdr_d;
  logic [LENGTH_BITS-1:0]              remain_q, remain_d;
  logic [LENGTH_BITS-1:0]              info_left_q, info_left_d;
  logic                                err_q, err_d;

  logic [BB-1:0]                       res_byte_d, res_byte_q;
  logic [shld_pkg::KindBits-1:0]       res_kind_d, res_kind_q;
  logic                                res_le_d, res_le_q;
  logic                                res_last_d, res_last_q;
  logic                                res_err_d, res_err_q;
  logic                                res_valid;

  logic                                in_acc;
  logic [HB-1:0]                       hdr_full;
  logic [WB-1:0]                       w0, w1, w2, w3;
  logic [shld_pkg::LineCfgBits-1:0]    limit;
  logic [shld_pkg::LineCfgBits-1:0]    line_next;
  logic                                line_done;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // The header is shifted in from the top, so byte 0 ends at the bottom.
  assign hdr_full = {in_byte_i, hdr_q[HB-1:BB]};
  assign w0 = hdr_full[0*WB +: WB];
  assign w1 = hdr_full[1*WB +: WB];
  assign w2 = hdr_full[2*WB +: WB];
  assign w3 = hdr_full[3*WB +: WB];

  assign limit     = (line_max_q > shld_pkg::LineCap) ? shld_pkg::LineCap : line_max_q;
  assign line_next = shld_pkg::LineCfgBits'(line_len_q) + 1'b1;
  assign line_done = (in_byte_i == shld_pkg::NewlineByte) || (line_next >= limit);

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    line_len_d  = line_len_q;
    hdr_d       = hdr_q;
    remain_d    = remain_q;
    info_left_d = info_left_q;
    err_d       = err_q;
    res_valid   = 1'b0;
    res_byte_d  = in_byte_i;
    res_kind_d  = shld_pkg::KindLog;
    res_le_d    = 1'b0;
    res_last_d  = 1'b0;
    res_err_d   = 1'b0;
    case (phase_q)
      PhIdle: begin
        if (in_byte_i == shld_pkg::SyncByte0) begin
          phase_d = PhSync1;
        end else begin
          res_valid  = 1'b1;
          res_le_d   = line_done;
          line_len_d = line_done ? '0 : line_next[shld_pkg::LineCntBits-1:0];
        end
      end
      PhSync1: begin
        phase_d = (in_byte_i == shld_pkg::SyncByte1) ? PhSync2 : PhIdle;
      end
      PhSync2: begin
        phase_d = (in_byte_i == shld_pkg::SyncByte2) ? PhSync3 : PhIdle;
      end
      PhSync3: begin
        hdr_cnt_d = '0;
        phase_d   = (in_byte_i == shld_pkg::SyncByte3) ? PhHeader : PhIdle;
      end
      PhHeader: begin
        hdr_d     = hdr_full;
        hdr_cnt_d = hdr_cnt_q + 1'b1;
        // Total and info are complete halfway through; compare them there.
        if (hdr_cnt_q == HdrHalf) begin
          err_d = hdr_q[HB/2 +: LENGTH_BITS] < hdr_q[HB/2 + WB +: LENGTH_BITS];
        end
        if (hdr_cnt_q == HdrLast) begin
          remain_d    = w0[LENGTH_BITS-1:0];
          info_left_d = w1[LENGTH_BITS-1:0];
          if ((w2 == magic_q) && ((w0 ^ w1 ^ w2 ^ w3) == '0)) begin
            phase_d = PhData;
          end else begin
            phase_d = PhIdle;
          end
        end
      end
      PhData: begin
        res_valid = 1'b1;
        if (remain_q == '0) begin
          res_byte_d = '0;
          res_kind_d = shld_pkg::KindEmpty;
          res_last_d = 1'b1;
          res_err_d  = err_q;
          phase_d    = PhIdle;
        end else begin
          res_kind_d = (info_left_q != '0) ? shld_pkg::KindInfo : shld_pkg::KindBody;
          if (info_left_q != '0) begin
            info_left_d = info_left_q - 1'b1;
          end
          remain_d = remain_q - 1'b1;
          if (remain_q == LENGTH_BITS'(1)) begin
            res_last_d = 1'b1;
            res_err_d  = err_q;
            phase_d    = PhIdle;
          end
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      hdr_cnt_q   <= '0;
      line_len_q  <= '0;
      out_valid_q <= 1'b0;
      magic_q     <= shld_pkg::MagicReset;
      line_max_q  <= shld_pkg::LineReset;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          shld_pkg::CfgMagic:   magic_q    <= cfg_data_i;
          shld_pkg::CfgLineMax: line_max_q <= cfg_data_i[shld_pkg::LineCfgBits-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_q     <= phase_d;
        hdr_cnt_q   <= hdr_cnt_d;
        line_len_q  <= line_len_d;
        out_valid_q <= res_valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hdr_q       <= hdr_d;
      remain_q    <= remain_d;
      info_left_q <= info_left_d;
      err_q       <= err_d;
      if (res_valid) begin
        res_byte_q <= res_byte_d;
        res_kind_q <= res_kind_d;
        res_le_q   <= res_le_d;
        res_last_q <= res_last_d;
        res_err_q  <= res_err_d;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = res_byte_q;
  assign byte_kind_o   = res_kind_q;
  assign line_end_o    = res_le_q;
  assign packet_last_o = res_last_q;
  assign split_error_o = res_err_q;

  // A log beat never closes a packet, and a payload beat never closes a line.
  a_log_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_kind_o == shld_pkg::KindLog) |-> !packet_last_o)
    else $error("log beat marked as packet end");

  a_payload_no_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_kind_o != shld_pkg::KindLog) |-> !line_end_o)
    else $error("payload beat marked as line end");

  a_err_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && split_error_o |-> packet_last_o)
    else $error("split error outside the last beat of a packet");

  a_empty_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_kind_o == shld_pkg::KindEmpty) |-> packet_last_o && (out_byte_o == '0))
    else $error("empty packet end malformed");

  a_last_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_valid && res_last_d |=> phase_q == PhIdle)
    else $error("parser not idle after packet end");

endmodule
